// ===== hw/rtl/fpr_pkg.sv =====
// Shared types and codes for the function entry/exit profiler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

	localparam logic [1:0] CMD_ENTER = 2'd0;
	localparam logic [1:0] CMD_EXIT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EXIT_RD,
		ST_EXIT_SUB,
		ST_EXIT_ADD,
		ST_FETCH,
		ST_DONE
	} fpr_state_t;

	typedef enum logic [1:0] {
		RSEL_SCAN,
		RSEL_SLOT,
		RSEL_RIDX
	} fpr_rsel_t;

	typedef struct packed {
		logic      ready;
		logic      rd_en;
		fpr_rsel_t rd_sel;
		logic      scan_clr;
		logic      scan_inc;
		logic      cap_match;
		logic      wr_time;
		logic      wr_alloc;
		logic      set_dropped;
		logic      sub_diff;
		logic      wr_total;
		logic      load_out;
	} fpr_cmd_t;

	typedef struct packed {
		logic is_event;
		logic is_enter;
		logic is_read;
		logic idx_ok;
		logic used_zero;
		logic full;
		logic scan_last;
		logic match;
		logic found;
		logic out_free;
	} fpr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fpr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fpr_ctrl.sv =====
// Sequencing state machine of the profiler: turns datapath status into commands.
// Depends on fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire fpr_pkg::fpr_status_t st,
	output fpr_pkg::fpr_cmd_t        cmd
);

	import fpr_pkg::*;

	fpr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (st.is_event) begin
					state_d = st.used_zero ? ST_DECIDE : ST_SCAN;
				end else if (st.is_read && st.idx_ok) begin
					state_d = ST_FETCH;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				// The first matching entry ends the search at once.
				if (st.match) state_d = ST_DECIDE;
				else if (st.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:    state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!st.is_enter && st.found) state_d = ST_EXIT_RD;
				else state_d = ST_DONE;
			end
			ST_EXIT_RD:  state_d = ST_EXIT_SUB;
			ST_EXIT_SUB: state_d = ST_EXIT_ADD;
			ST_EXIT_ADD: state_d = ST_DONE;
			ST_FETCH:    state_d = ST_DONE;
			ST_DONE: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RSEL_SCAN;
		case (state_q)
			ST_IDLE:     cmd.ready = 1'b1;
			ST_DISPATCH: cmd.scan_clr = 1'b1;
			ST_SCAN: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RSEL_SCAN;
				cmd.scan_inc  = 1'b1;
				cmd.cap_match = 1'b1;
			end
			ST_DRAIN:    cmd.cap_match = 1'b1;
			ST_DECIDE: begin
				if (st.is_enter) begin
					if (st.found) cmd.wr_time = 1'b1;
					else if (!st.full) cmd.wr_alloc = 1'b1;
					else cmd.set_dropped = 1'b1;
				end
			end
			ST_EXIT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RSEL_SLOT;
			end
			ST_EXIT_SUB: cmd.sub_diff = 1'b1;
			ST_EXIT_ADD: cmd.wr_total = 1'b1;
			ST_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RSEL_RIDX;
			end
			ST_DONE:     cmd.load_out = st.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fpr_dp.sv =====
// Datapath of the profiler: item registers, the three entry tables, the used
// count, the search pipeline and the output register. Depends on fpr_pkg, fpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module fpr_dp #(
	parameter int TABLE_DEPTH = 32,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((3 + 128 + CNT_W + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpr_pkg::fpr_cmd_t  cmd,
	output fpr_pkg::fpr_status_t    st,
	input  wire logic               cfg_wr_en,
	input  wire logic [3:0]         cfg_wr_data,
	input  wire logic               in_accept,
	input  wire logic [1:0]         in_command,
	input  wire logic [3:0]         in_hart,
	input  wire logic [63:0]        in_addr,
	input  wire logic [63:0]        in_ts,
	input  wire logic [4:0]         in_ridx,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic      [OUT_W-1:0]   out_data
);

	import fpr_pkg::*;

	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	logic [3:0]       watched_q;
	logic [1:0]       cmd_q;
	logic [3:0]       hart_q;
	logic [63:0]      faddr_q;
	logic [63:0]      ts_q;
	logic [4:0]       ridx_q;
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] slot_q;
	logic             found_q;
	logic             dropped_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [63:0]      diff_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic [63:0]      addr_rdata;
	logic [63:0]      time_rdata;
	logic [63:0]      total_rdata;
	logic [63:0]      total_wdata;
	logic             entry_ok;
	logic [OUT_W-1:0] out_word;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q   <= '0;
			cmd_q       <= CMD_ENTER;
			used_q      <= '0;
			scan_q      <= '0;
			found_q     <= 1'b0;
			dropped_q   <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) watched_q <= cfg_wr_data;
			if (in_accept) begin
				cmd_q     <= in_command;
				found_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
			if (cmd.wr_alloc) used_q <= used_q + CNT_W'(1);
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_inc) scan_q <= scan_q + IDX_W'(1);
			if (cmd.cap_match && st.match) found_q <= 1'b1;
			if (cmd.set_dropped) dropped_q <= 1'b1;
			cmp_vld_s1 <= cmd.rd_en && (cmd.rd_sel == RSEL_SCAN);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			hart_q  <= in_hart;
			faddr_q <= in_addr;
			ts_q    <= in_ts;
			ridx_q  <= in_ridx;
		end
		cmp_idx_s1 <= scan_q;
		if (cmd.cap_match && st.match) slot_q <= cmp_idx_s1;
		if (cmd.sub_diff) diff_q <= ts_q - time_rdata;
		if (cmd.load_out) out_data_q <= out_word;
	end

	assign entry_ok = (cmd_q == CMD_READ) && (CMP_W'(ridx_q) < CMP_W'(used_q));

	assign out_word = OUT_W'({used_q,
		entry_ok ? total_rdata : 64'd0,
		entry_ok ? addr_rdata : 64'd0,
		entry_ok, dropped_q, found_q});

	always_comb begin
		case (cmd.rd_sel)
			RSEL_SCAN: raddr = scan_q;
			RSEL_SLOT: raddr = slot_q;
			RSEL_RIDX: raddr = IDX_W'(ridx_q);
			default:   raddr = scan_q;
		endcase
	end

	// A new entry goes to the first free slot; updates go to the found slot.
	assign waddr       = cmd.wr_alloc ? IDX_W'(used_q) : slot_q;
	assign total_wdata = cmd.wr_alloc ? 64'd0 : total_rdata + diff_q;

	fpr_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_addr_ram (
		.clk  (clk),
		.we   (cmd.wr_alloc),
		.waddr(waddr),
		.wdata(faddr_q),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(addr_rdata)
	);

	fpr_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_time_ram (
		.clk  (clk),
		.we   (cmd.wr_alloc | cmd.wr_time),
		.waddr(waddr),
		.wdata(ts_q),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(time_rdata)
	);

	fpr_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_total_ram (
		.clk  (clk),
		.we   (cmd.wr_alloc | cmd.wr_total),
		.waddr(waddr),
		.wdata(total_wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(total_rdata)
	);

	always_comb begin
		st           = '0;
		st.is_event  = ((cmd_q == CMD_ENTER) || (cmd_q == CMD_EXIT)) && (hart_q == watched_q);
		st.is_enter  = (cmd_q == CMD_ENTER);
		st.is_read   = (cmd_q == CMD_READ);
		st.idx_ok    = entry_ok;
		st.used_zero = (used_q == '0);
		st.full      = (used_q == CNT_W'(TABLE_DEPTH));
		st.scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == used_q);
		st.match     = cmp_vld_s1 && (addr_rdata == faddr_q);
		st.found     = found_q;
		st.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/function_entry_exit_profiler.sv =====
// Top level of the function entry/exit profiler: stream ports, controller and
// datapath. Depends on fpr_pkg, fpr_ctrl, fpr_dp (and through it fpr_ram).
//
// The profiler keeps up to TABLE_DEPTH function entries, each with its
// address, last entry time and accumulated ticks. Enter and exit events
// search the used entries one per cycle through the address RAM; a hit ends
// the search early. A read of a used entry fetches it from the tables; a
// read beyond the used count, an event from another hart or the unused
// command is answered without a table access.
// Results wait in an output register; a new event is taken while an older
// result is still pending, and it stalls only if it finishes before that
// result is taken. The tables need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module function_entry_exit_profiler #(
	parameter int TABLE_DEPTH = 32,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((3 + 128 + CNT_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [3:0]       cfg_wr_data,    // watched_hart
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [143:0]     s_tdata,        // hart_id, func_addr, timestamp, read_index
	input  wire logic [1:0]       s_tuser,        // command
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata         // hit, dropped, entry_valid, entry_addr,
	                                              // entry_total, used_count
);

	import fpr_pkg::*;

	fpr_cmd_t    cmd;
	fpr_status_t st;
	logic        in_accept;

	assign s_tready  = cmd.ready;
	assign in_accept = s_tvalid && cmd.ready;

	fpr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.st      (st),
		.cmd     (cmd)
	);

	fpr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_accept  (in_accept),
		.in_command (s_tuser),
		.in_hart    (s_tdata[3:0]),
		.in_addr    (s_tdata[67:4]),
		.in_ts      (s_tdata[131:68]),
		.in_ridx    (s_tdata[136:132]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== tb/sv/function_entry_exit_profiler_test.sv =====
// Self-checking testbench for the function entry/exit profiler top level.
// Depends on fpr_pkg and function_entry_exit_profiler; an internal table model
// predicts every result, and stream traffic is driven with random idling.
`timescale 1ns / 1ps

module function_entry_exit_profiler_test;
	import fpr_pkg::*;

	localparam int DEPTH = 32;
	localparam int OUT_W = 144;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  hart;
		logic [63:0] addr;
		logic [63:0] stamp;
		logic [4:0]  ridx;
	} prof_item_t;

	typedef struct packed {
		logic        hit;
		logic        dropped;
		logic        valid;
		logic [63:0] addr;
		logic [63:0] total;
		logic [5:0]  used;
	} prof_result_t;

	// Mirror of the profiler table; it predicts one result per accepted transaction.
	class profile_scoreboard;
		logic [63:0] fn_addr[DEPTH];
		logic [63:0] enter_stamp[DEPTH];
		logic [63:0] ticks[DEPTH];
		int unsigned used;
		logic [3:0] watched;
		prof_result_t due_results[$];
		int errors;

		function new();
			used = 0;
			watched = '0;
			errors = 0;
		endfunction

		function void set_watched(logic [3:0] h);
			watched = h;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function void take_event(prof_item_t it);
			prof_result_t r;
			int slot;
			bit found;
			r = '0;
			found = 0;
			slot = 0;
			if ((it.cmd == CMD_ENTER || it.cmd == CMD_EXIT) && it.hart == watched) begin
				for (int k = 0; k < used; k++) begin
					if (!found && fn_addr[k] == it.addr) begin
						found = 1;
						slot = k;
					end
				end
				r.hit = found;
				if (it.cmd == CMD_ENTER) begin
					if (!found) begin
						if (used < DEPTH) begin
							slot = used;
							used++;
							fn_addr[slot] = it.addr;
							ticks[slot] = '0;
							found = 1;
						end else begin
							r.dropped = 1'b1;
						end
					end
					if (found)
						enter_stamp[slot] = it.stamp;
				end else if (found) begin
					ticks[slot] = ticks[slot] + (it.stamp - enter_stamp[slot]);
				end
			end else if (it.cmd == CMD_READ && it.ridx < used) begin
				r.valid = 1'b1;
				r.addr = fn_addr[it.ridx];
				r.total = ticks[it.ridx];
			end
			r.used = used[5:0];
			due_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			prof_result_t want;
			prof_result_t got;
			got = '{hit: d[0], dropped: d[1], valid: d[2], addr: d[66:3],
				total: d[130:67], used: d[136:131]};
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: hit=%b dropped=%b valid=%b addr=%h total=%h used=%0d",
						got.hit, got.dropped, got.valid, got.addr, got.total, got.used);
				return;
			end
			want = due_results.pop_front();
			if (got.hit !== want.hit || got.dropped !== want.dropped ||
					got.valid !== want.valid || got.addr !== want.addr ||
					got.total !== want.total || got.used !== want.used) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected hit=%b dropped=%b valid=%b addr=%h total=%h used=%0d",
						want.hit, want.dropped, want.valid, want.addr, want.total, want.used);
					$display("          actual   hit=%b dropped=%b valid=%b addr=%h total=%h used=%0d",
						got.hit, got.dropped, got.valid, got.addr, got.total, got.used);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [143:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	profile_scoreboard ledger = new();
	int idle_pct = 28;
	bit hold_req = 0;
	logic [3:0] cur_watch = '0;
	logic [63:0] run_tick;
	logic [63:0] addr_pool[$];
	int counted = 0;

	function_entry_exit_profiler #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is bounded by item count; 5 ms is far above the slowest correct run.
	initial begin
		#5ms;
		$display("function_entry_exit_profiler_test failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready = ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_result(m_tdata);
	end

	task automatic send_item(input logic [1:0] cmd, input logic [3:0] hart,
			input logic [63:0] addr, input logic [63:0] stamp, input logic [4:0] ridx);
		prof_item_t it;
		it = '{cmd: cmd, hart: hart, addr: addr, stamp: stamp, ridx: ridx};
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {7'd0, ridx, stamp, addr, hart};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ledger.take_event(it);
		counted++;
	endtask

	// Lets every pending result drain, then writes the watched hart.
	task automatic set_watch(input logic [3:0] h);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = h;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ledger.set_watched(h);
		cur_watch = h;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_addr();
		logic [63:0] a;
		if (addr_pool.size() < 56 && $urandom_range(0, 99) < 25) begin
			a = rand64();
			addr_pool.push_back(a);
			return a;
		end
		return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
	endfunction

	function automatic logic [3:0] pick_hart();
		if ($urandom_range(0, 99) < 85)
			return cur_watch;
		return 4'($urandom_range(0, 15));
	endfunction

	// Mostly enter/exit pairs on one address with a rising tick count,
	// mixed with reads and fully random transactions.
	task automatic run_phase(input int n);
		int stop_at;
		int r;
		logic [63:0] a;
		logic [3:0] h;
		stop_at = counted + n;
		while (counted < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				a = pick_addr();
				h = pick_hart();
				send_item(CMD_ENTER, h, a, run_tick, 5'($urandom));
				run_tick += 64'($urandom_range(1, 5000));
				if ($urandom_range(0, 99) < 30)
					send_item(CMD_READ, 4'($urandom), rand64(), rand64(), 5'($urandom));
				if ($urandom_range(0, 99) < 10)
					h = 4'($urandom);
				send_item(CMD_EXIT, h, a, run_tick, 5'($urandom));
				run_tick += 64'($urandom_range(0, 300));
			end else if (r < 80) begin
				send_item(CMD_READ, 4'($urandom), rand64(), rand64(), 5'($urandom));
			end else begin
				a = ($urandom_range(0, 1) == 0) ? rand64() : pick_addr();
				send_item(2'($urandom), 4'($urandom), a, rand64(), 5'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ENTER;
		run_tick = rand64();
		addr_pool.push_back(64'd0);
		addr_pool.push_back('1);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_watch(4'd0);
		send_item(CMD_READ, 4'd0, '0, '0, 5'd0);
		send_item(CMD_READ, 4'd15, '1, '1, 5'd31);
		send_item(CMD_ENTER, 4'd0, 64'd0, 64'd100, 5'd0);
		send_item(CMD_ENTER, 4'd0, '1, '1, 5'd31);
		// Exits with a smaller stamp than the entry wrap around.
		send_item(CMD_EXIT, 4'd0, 64'd0, 64'd50, 5'd0);
		send_item(CMD_EXIT, 4'd0, '1, 64'd5, 5'd0);
		send_item(CMD_EXIT, 4'd0, 64'h1234_5678_9abc_def0, 64'd7, 5'd0);
		send_item(CMD_ENTER, 4'd5, 64'hdead_beef, 64'd9, 5'd0);
		send_item(CMD_EXIT, 4'd15, 64'd0, 64'd900, 5'd0);
		send_item(CMD_UNUSED, 4'd0, 64'd0, 64'd1, 5'd1);
		send_item(CMD_ENTER, 4'd0, 64'd0, 64'd1000, 5'd0);
		send_item(CMD_EXIT, 4'd0, 64'd0, 64'd3000, 5'd0);
		send_item(CMD_READ, 4'd0, '0, '0, 5'd0);
		send_item(CMD_READ, 4'd0, '0, '0, 5'd1);
		send_item(CMD_READ, 4'd0, '0, '0, 5'd2);
		send_item(CMD_READ, 4'd0, '0, '0, 5'd31);

		set_watch(4'd15);
		send_item(CMD_ENTER, 4'd15, 64'h8000_0000_0000_0000, 64'd10, 5'd0);
		send_item(CMD_ENTER, 4'd0, 64'h8000_0000_0000_0000, 64'd20, 5'd0);
		send_item(CMD_EXIT, 4'd15, 64'h8000_0000_0000_0000, 64'd40, 5'd0);
		send_item(CMD_READ, 4'd3, '0, '0, 5'd2);

		// The receiver holds off while the sender keeps offering.
		hold_req = 1;
		run_phase(150);
		set_watch(4'd0);
		idle_pct = 0;
		run_phase(150);
		idle_pct = 28;
		set_watch(4'($urandom));
		run_phase(150);
		set_watch(4'd9);
		run_phase(150);
		set_watch(4'd15);
		run_phase(150);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (ledger.errors == 0 && ledger.outstanding() == 0) begin
			$display("function_entry_exit_profiler_test passed");
		end else begin
			$display("function_entry_exit_profiler_test failed");
		end
		$finish;
	end

endmodule
